/* sv/gbp_pkg.sv */
// gbp_pkg: shared types and constants for the gshare branch predictor
`timescale 1ns / 1ps

package gbp_pkg;

   // fixed field widths
   localparam int PC_W      = 32;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CNT_W     = 32;
   localparam int CTR_W     = 2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_BITS = 1'b1;

   // register reset values
   localparam logic [CFG_W-1:0] INDEX_BITS_RST   = 4'd12;
   localparam logic [CFG_W-1:0] HISTORY_BITS_RST = 4'd0;

   // two-bit counter codes
   localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;
   localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
   localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [PC_W-1:0] branch_pc;
      logic            taken;
   } req_type;

   typedef struct packed {
      logic             predicted_taken;
      logic             mispredicted;
      logic [CNT_W-1:0] branch_total;
      logic [CNT_W-1:0] mispredict_total;
   } rsp_type;

endpackage

/* sv/gbp_front.sv */
// gbp_front: config registers, global history and table index for each accepted item
`timescale 1ns / 1ps

module gbp_front #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gbp_pkg::req_type             req_data,
   input  logic                         csr_wr_en,
   input  logic [gbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbp_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                         q_full,
   input  logic                         clearing,
   output logic                         push_vld,
   output logic [MAX_INDEX_BITS:0]      push_data
);
   import gbp_pkg::*;

   localparam int IW  = MAX_INDEX_BITS;
   localparam int MW0 = $clog2(MAX_INDEX_BITS + 1);
   localparam int MW  = (MW0 > CFG_W) ? MW0 : CFG_W;
   localparam logic [MW-1:0] MAX_M = MW'(IW);
   localparam logic [MW-1:0] ONE_M = MW'(1);

   logic [CFG_W-1:0] index_bits_ff;
   logic [CFG_W-1:0] history_bits_ff;
   logic [IW-1:0]    hist_ff;
   logic [IW-1:0]    hist_in;
   logic [MW-1:0]    index_bits_x;
   logic [MW-1:0]    history_bits_x;
   logic [MW-1:0]    m_eff;
   logic [MW-1:0]    n_eff;
   logic [IW-1:0]    m_mask;
   logic [IW-1:0]    n_mask;
   logic [IW-1:0]    hist_cur;
   logic [IW-1:0]    pc_bits;
   logic [IW-1:0]    hist_term;
   logic [IW-1:0]    idx;
   logic             accept;

   // back pressure from the queue and from the table clearing pass
   assign req_stall = q_full || clearing;
   assign accept    = req_valid && !req_stall;

   // effective index width and history length
   always_comb begin
      index_bits_x   = MW'(index_bits_ff);
      history_bits_x = MW'(history_bits_ff);
      priority if (index_bits_x == '0) begin
         m_eff = ONE_M;
      end else if (index_bits_x > MAX_M) begin
         m_eff = MAX_M;
      end else begin
         m_eff = index_bits_x;
      end
      n_eff = (history_bits_x > m_eff) ? m_eff : history_bits_x;
   end

   // index: pc bits xor history aligned to the top of the index
   always_comb begin
      m_mask    = ~({IW{1'b1}} << m_eff);
      n_mask    = ~({IW{1'b1}} << n_eff);
      hist_cur  = hist_ff & n_mask;
      pc_bits   = req_data.branch_pc[IW+1:2] & m_mask;
      hist_term = (hist_cur << (m_eff - n_eff)) & m_mask;
      idx       = pc_bits ^ hist_term;
      if (n_eff == '0) begin
         hist_in = '0;
      end else begin
         hist_in = (hist_cur >> 1) | (IW'(req_data.taken) << (n_eff - ONE_M));
      end
   end

   assign push_vld  = accept;
   assign push_data = {idx, req_data.taken};

   // config registers and history
   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= INDEX_BITS_RST;
         history_bits_ff <= HISTORY_BITS_RST;
         hist_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_INDEX_BITS:   index_bits_ff   <= csr_wdata;
               CSR_HISTORY_BITS: history_bits_ff <= csr_wdata;
               default:          ;
            endcase
         end
         if (accept) begin
            hist_ff <= hist_in;
         end
      end
   end

endmodule

/* sv/gbp_queue.sv */
// gbp_queue: small fifo that decouples index generation from the table update
`timescale 1ns / 1ps

module gbp_queue #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             q_vld,
   output logic             q_full,
   output logic [WIDTH-1:0] q_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign q_vld  = (count_ff != '0);
   assign q_full = (count_ff == FULL);
   assign q_data = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // no overflow and no underflow
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push || pop)
      else $error("item pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_vld)
      else $error("item popped from an empty queue");

endmodule

/* sv/gbp_back.sv */
// gbp_back: counter table read-modify-write, running totals and result register
`timescale 1ns / 1ps

module gbp_back #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_vld,
   input  logic [MAX_INDEX_BITS:0] q_data,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output gbp_pkg::rsp_type        rsp_data
);
   import gbp_pkg::*;

   localparam int IW    = MAX_INDEX_BITS;
   localparam int DEPTH = 2 ** IW;

   logic [CTR_W-1:0] mem [DEPTH];
   logic [CTR_W-1:0] rd_data_ff;
   logic             fwd_vld_ff;
   logic [CTR_W-1:0] fwd_val_ff;
   logic             b_vld_ff;
   logic [IW-1:0]    b_idx_ff;
   logic             b_taken_ff;
   logic             clearing_ff;
   logic [IW-1:0]    clr_idx_ff;
   logic [CNT_W-1:0] branch_cnt_ff;
   logic [CNT_W-1:0] branch_cnt_in;
   logic [CNT_W-1:0] miss_cnt_ff;
   logic [CNT_W-1:0] miss_cnt_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [IW-1:0]    q_idx;
   logic             b_go;
   logic [CTR_W-1:0] ctr_cur;
   logic [CTR_W-1:0] ctr_new;
   logic             pred;
   logic             miss;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [CTR_W-1:0] wr_val;

   assign q_idx     = q_data[IW:1];
   assign clearing  = clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // update stage moves when the result register is free or draining
   assign b_go = b_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop  = q_vld && !clearing_ff && (!b_vld_ff || b_go);

   // counter with bypass of the write made at the edge of the read
   always_comb begin
      ctr_cur = fwd_vld_ff ? fwd_val_ff : rd_data_ff;
      pred    = ctr_cur[1];
      miss    = (pred != b_taken_ff);
      if (b_taken_ff) begin
         ctr_new = (ctr_cur == CTR_MAX) ? CTR_MAX : ctr_cur + 1'b1;
      end else begin
         ctr_new = (ctr_cur == CTR_MIN) ? CTR_MIN : ctr_cur - 1'b1;
      end
      branch_cnt_in = (branch_cnt_ff == '1) ? branch_cnt_ff : branch_cnt_ff + 1'b1;
      miss_cnt_in   = (miss && (miss_cnt_ff != '1)) ? miss_cnt_ff + 1'b1 : miss_cnt_ff;
   end

   // table write port: clearing pass or counter update
   always_comb begin
      wr_en   = clearing_ff || b_go;
      wr_addr = clearing_ff ? clr_idx_ff : b_idx_ff;
      wr_val  = clearing_ff ? CTR_WEAK_TAKEN : ctr_new;
   end

   // counter table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_val;
      end
      if (pop) begin
         rd_data_ff <= mem[q_idx];
      end
   end

   // update stage payload and result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         b_idx_ff   <= q_idx;
         b_taken_ff <= q_data[0];
         fwd_val_ff <= ctr_new;
      end
      if (b_go) begin
         rsp_data_ff.predicted_taken  <= pred;
         rsp_data_ff.mispredicted     <= miss;
         rsp_data_ff.branch_total     <= branch_cnt_in;
         rsp_data_ff.mispredict_total <= miss_cnt_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         b_vld_ff      <= 1'b0;
         fwd_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         branch_cnt_ff <= '0;
         miss_cnt_ff   <= '0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (pop) begin
            b_vld_ff   <= 1'b1;
            fwd_vld_ff <= b_go && (b_idx_ff == q_idx);
         end else if (b_go) begin
            b_vld_ff <= 1'b0;
         end
         if (b_go) begin
            rsp_valid_ff  <= 1'b1;
            branch_cnt_ff <= branch_cnt_in;
            miss_cnt_ff   <= miss_cnt_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // nothing in flight while the table is being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !b_vld_ff && !rsp_valid_ff)
      else $error("item in flight during table clearing");

   // misses never outrun branches
   a_miss_le_branch: assert property (@(posedge clock) disable iff (reset)
      miss_cnt_ff <= branch_cnt_ff)
      else $error("mispredict count above branch count");

   // a held update stage keeps its counter value
   a_hold_ctr: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !b_go |=> $stable(ctr_cur) && b_vld_ff)
      else $error("counter value changed while update stage held");

endmodule

/* sv/gshare_branch_predictor.sv */
// gshare_branch_predictor: top level of the gshare branch direction predictor
`timescale 1ns / 1ps
//
// Each req item is one resolved branch (pc and outcome). The block forms the
// table index from pc bits [M+1:2] xor the global history, predicts from the
// two-bit counter there, updates the counter and history, and returns one rsp
// item with the prediction, the mispredict flag and saturating running totals.
// Channels use valid/stall: an item moves at an edge with valid high and stall
// low. Throughput is one item per cycle while rsp_stall is low and the table
// is not being swept, set by the single table write port. From req acceptance
// to rsp valid an item passes a queue slot, then the table read into the update
// stage, then the rsp register, which the update loads. A short queue sits
// between index generation and the table update, so req keeps flowing while
// rsp is stalled until the queue fills; the rsp register holds its item for as
// long as rsp_stall is high. After reset the table is swept to weakly taken,
// one entry a cycle, across all 2**MAX_INDEX_BITS entries (4096 by default);
// req_stall stays high during the sweep. csr writes (index_bits, history_bits)
// are taken at any time, but are meant to be written while the block is idle.
//
module gshare_branch_predictor #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gbp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gbp_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbp_pkg::CFG_W-1:0]     csr_wdata
);
   import gbp_pkg::*;

   localparam int QW = MAX_INDEX_BITS + 1;

   logic          push_vld;
   logic [QW-1:0] push_data;
   logic          pop;
   logic          q_vld;
   logic          q_full;
   logic [QW-1:0] q_data;
   logic          clearing;

   // index generation and history
   gbp_front #(
      .MAX_INDEX_BITS(MAX_INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .clearing  (clearing),
      .push_vld  (push_vld),
      .push_data (push_data)
   );

   // decoupling queue
   gbp_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_vld),
      .push_data (push_data),
      .pop       (pop),
      .q_vld     (q_vld),
      .q_full    (q_full),
      .q_data    (q_data)
   );

   // table update and results
   gbp_back #(
      .MAX_INDEX_BITS(MAX_INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_vld     (q_vld),
      .q_data    (q_data),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/gbp_branch_checker.sv */
// gbp_branch_checker: predicts and checks every rsp item of the gshare branch predictor
`timescale 1ns / 1ps

module gbp_branch_checker #(
   parameter int TABLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  gbp_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  gbp_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbp_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            outcomes_due
);
   import gbp_pkg::*;

   // shadow copy of the predictor state
   logic [CTR_W-1:0]      counter_tab [2**TABLE_BITS];
   logic [TABLE_BITS-1:0] path_history;
   logic [CNT_W-1:0]      branches_seen;
   logic [CNT_W-1:0]      misses_seen;
   logic [CFG_W-1:0]      index_cfg;
   logic [CFG_W-1:0]      history_cfg;

   rsp_type               due_outcomes [$];
   int                    mismatches = 0;

   // look up, train and count one resolved branch
   function automatic rsp_type predict_branch(input req_type br);
      int unsigned           m;
      int unsigned           n;
      logic [31:0]           field_mask;
      logic [31:0]           hist_mask;
      logic [31:0]           hist_now;
      logic [31:0]           hist_term;
      logic [31:0]           hist_next;
      logic [TABLE_BITS-1:0] slot;
      logic [CTR_W-1:0]      ctr;
      rsp_type               res;

      // effective index width and history length
      m = 32'(index_cfg);
      if (m < 1) m = 1;
      if (m > TABLE_BITS) m = TABLE_BITS;
      n = 32'(history_cfg);
      if (n > m) n = m;
      field_mask = (32'd1 << m) - 32'd1;
      hist_mask  = (32'd1 << n) - 32'd1;

      // history sits at the top of the index field
      hist_now  = {{(32-TABLE_BITS){1'b0}}, path_history} & hist_mask;
      hist_term = hist_now << (m - n);
      slot      = TABLE_BITS'(((br.branch_pc >> 2) ^ hist_term) & field_mask);

      ctr                 = counter_tab[slot];
      res.predicted_taken = (ctr >= CTR_WEAK_TAKEN);
      res.mispredicted    = (res.predicted_taken != br.taken);

      // saturating two-bit counter update
      if (br.taken && ctr != CTR_MAX) begin
         ctr = ctr + 1'b1;
      end else if (!br.taken && ctr != CTR_MIN) begin
         ctr = ctr - 1'b1;
      end
      counter_tab[slot] = ctr;

      // outcome enters the history at bit n-1
      if (n > 0) begin
         hist_next    = (hist_now >> 1) | ({31'd0, br.taken} << (n - 1));
         path_history = TABLE_BITS'(hist_next & hist_mask);
      end else begin
         path_history = '0;
      end

      // running totals stick at all ones
      if (branches_seen != '1) branches_seen = branches_seen + 1'b1;
      if (res.mispredicted && misses_seen != '1) misses_seen = misses_seen + 1'b1;
      res.branch_total     = branches_seen;
      res.mispredict_total = misses_seen;
      return res;
   endfunction

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         foreach (counter_tab[i]) counter_tab[i] = CTR_WEAK_TAKEN;
         path_history  = '0;
         branches_seen = '0;
         misses_seen   = '0;
         index_cfg     = INDEX_BITS_RST;
         history_cfg   = HISTORY_BITS_RST;
         due_outcomes.delete();
      end else begin
         // delivered item against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (due_outcomes.size() == 0) begin
               $display("%0t: no item expected, actual %0h", $time, rsp_data);
               mismatches++;
            end else begin
               want = due_outcomes.pop_front();
               flag_field("predicted_taken", 32'(want.predicted_taken),
                          32'(rsp_data.predicted_taken));
               flag_field("mispredicted", 32'(want.mispredicted),
                          32'(rsp_data.mispredicted));
               flag_field("branch_total", want.branch_total, rsp_data.branch_total);
               flag_field("mispredict_total", want.mispredict_total,
                          rsp_data.mispredict_total);
            end
         end

         // accepted branch
         if (req_valid && !req_stall) begin
            fresh = predict_branch(req_data);
            due_outcomes.insert(due_outcomes.size(), fresh);
         end

         // register writes
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_INDEX_BITS: begin
                  index_cfg = csr_wdata;
               end
               CSR_HISTORY_BITS: begin
                  history_cfg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      mismatch_count <= mismatches;
      outcomes_due   <= due_outcomes.size();
   end

endmodule

/* tb/tb_gshare_branch_predictor.sv */
// tb_gshare_branch_predictor: stimulus and verdict for the gshare branch predictor
`timescale 1ns / 1ps

module tb_gshare_branch_predictor;
   import gbp_pkg::*;

   localparam int TABLE_BITS    = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOT_BRANCHES  = 16;
   localparam int SEGMENTS      = 9;
   localparam int SEGMENT_ITEMS = 84;

   // behavior of a frequently seen branch
   typedef enum logic [1:0] {
      KIND_MOSTLY_TAKEN,
      KIND_MOSTLY_NOT_TAKEN,
      KIND_ALTERNATING,
      KIND_COIN_FLIP
   } branch_kind_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INDEX_BITS;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int                   mismatch_count;
   int                   outcomes_due;
   int unsigned          send_gap_pct = 27;
   int unsigned          stall_pct    = 47;
   int                   cycles       = 0;

   // settings per random segment, extremes included
   logic [CFG_W-1:0]     seg_index_bits   [SEGMENTS] =
      '{4'd0, 4'd15, 4'd4, 4'd12, 4'd1, 4'd8, 4'd13, 4'd6, 4'd10};
   logic [CFG_W-1:0]     seg_history_bits [SEGMENTS] =
      '{4'd0, 4'd15, 4'd9, 4'd12, 4'd1, 4'd3, 4'd0, 4'd6, 4'd5};

   logic [PC_W-1:0]      hot_pc   [HOT_BRANCHES];
   branch_kind_type      hot_kind [HOT_BRANCHES];
   logic                 hot_last [HOT_BRANCHES];

   gshare_branch_predictor #(
      .MAX_INDEX_BITS(TABLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gbp_branch_checker #(
      .TABLE_BITS(TABLE_BITS)
   ) outcome_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outcomes_due   (outcomes_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // run time guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // offer one branch, called and returning at a falling edge
   task automatic send_branch(input logic [PC_W-1:0] pc, input logic tk);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_data.branch_pc = pc;
      req_data.taken     = tk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] which,
                            input logic [CFG_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = which;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // stop offering and wait for every outstanding item
   task automatic drain;
      req_valid = 1'b0;
      while (outcomes_due != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [PC_W-1:0] pc;
      logic            tk;
      int              k;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed items at reset settings
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      // counter saturates at the top, then at the bottom
      repeat (4) send_branch(32'h0000_0100, 1'b1);
      repeat (5) send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h0000_0100, 1'b1);
      // low two pc bits never select an entry
      send_branch(32'h0000_0201, 1'b0);
      send_branch(32'h0000_0202, 1'b0);
      send_branch(32'h0000_0203, 1'b0);
      // pc bits above the index alias onto one entry
      send_branch(32'hABCD_4300, 1'b0);
      send_branch(32'h5432_C300, 1'b0);
      send_branch(32'h0000_0300, 1'b1);
      send_branch(32'hAAAA_AAAA, 1'b1);
      send_branch(32'h5555_5555, 1'b0);
      drain();

      // pool of recurring branches
      for (k = 0; k < HOT_BRANCHES; k++) begin
         hot_pc[k]   = $urandom;
         hot_kind[k] = branch_kind_type'($urandom_range(3));
         hot_last[k] = 1'b0;
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // idling pattern by thirds of the run
         if (seg < SEGMENTS / 3) begin
            send_gap_pct = 27;
            stall_pct    = 47;
         end else if (seg < 2 * SEGMENTS / 3) begin
            send_gap_pct = 47;
            stall_pct    = 27;
         end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         write_csr(CSR_INDEX_BITS, seg_index_bits[seg]);
         write_csr(CSR_HISTORY_BITS, seg_history_bits[seg]);

         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            // mostly recurring branches with patterned outcomes, some noise
            if ($urandom_range(99) < 75) begin
               k  = $urandom_range(HOT_BRANCHES - 1);
               pc = hot_pc[k];
               case (hot_kind[k])
                  KIND_MOSTLY_TAKEN: begin
                     tk = ($urandom_range(99) < 92);
                  end
                  KIND_MOSTLY_NOT_TAKEN: begin
                     tk = ($urandom_range(99) < 8);
                  end
                  KIND_ALTERNATING: begin
                     tk = !hot_last[k];
                  end
                  default: begin
                     tk = 1'($urandom_range(1));
                  end
               endcase
               hot_last[k] = tk;
            end else begin
               pc = $urandom;
               tk = 1'($urandom_range(1));
            end
            send_branch(pc, tk);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/gbp_pkg.sv
sv/gbp_front.sv
sv/gbp_queue.sv
sv/gbp_back.sv
sv/gshare_branch_predictor.sv
tb/gbp_branch_checker.sv
tb/tb_gshare_branch_predictor.sv
